/* hdl/sha_pkg.sv */
// ---------------------------------------------------------------------------
// sha_pkg: shared types and constants
// round constants, initial hash values and controller types for the hasher
// ---------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic pad_start;
    logic pad_final;
    logic load_win;
    logic do_round;
    logic fold;
    logic restart;
  } cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] PAD_LIMIT = 7'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* hdl/sha_if.sv */
// ---------------------------------------------------------------------------
// sha_in_if / sha_out_if: request channels
// valid/ready channels for message bytes and digests
// ---------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_bits_255_192;
  logic [63:0] digest_bits_191_128;
  logic [63:0] digest_bits_127_64;
  logic [63:0] digest_bits_63_0;
  modport source (output valid, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, input ready);
  modport sink (input valid, digest_bits_255_192, digest_bits_191_128,
                digest_bits_127_64, digest_bits_63_0, output ready);
endinterface
`default_nettype wire

/* hdl/sha_datapath.sv */
// ---------------------------------------------------------------------------
// sha_datapath: block buffer, schedule and round logic
// one round per cycle, chaining words, byte packing and padding
// ---------------------------------------------------------------------------
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic [7:0]  byte_in,
  input  wire logic [5:0]  round_idx,
  output logic             block_full,
  output logic             need_extra,
  output logic [255:0]     digest
);

  logic [31:0] blk_r [16];
  logic [31:0] win_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [6:0]  fill_r;
  logic [60:0] len_r;

  logic [31:0] w_cur, s0, s1, t1, t2;
  logic [63:0] bits;
  logic [3:0]  widx;
  logic [1:0]  bsel;

  assign block_full = (fill_r == 7'd63);
  assign need_extra = (fill_r >= PAD_LIMIT);
  assign bits = {len_r, 3'b000};
  assign widx = fill_r[5:2];
  assign bsel = fill_r[1:0];

  always_comb begin
    s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_cur = (round_idx < 6'd16) ? win_r[0] : (win_r[0] + s0 + win_r[9] + s1);
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + K[round_idx] + w_cur;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // window shifts each round so taps sit at fixed slots
  always_ff @(posedge clk) begin
    if (cmd.take_byte || cmd.pad_start) begin
      for (int i = 0; i < 4; i++) begin
        if (bsel == 2'(i)) begin
          blk_r[widx][31 - 8 * i -: 8] <= cmd.pad_start ? PAD_BYTE : byte_in;
        end else if (cmd.pad_start && bsel < 2'(i)) begin
          blk_r[widx][31 - 8 * i -: 8] <= 8'h00;
        end
      end
      if (cmd.pad_start) begin
        for (int j = 0; j < 16; j++) begin
          if (4'(j) > widx) blk_r[j] <= 32'h0;
        end
        if (!need_extra) begin
          blk_r[14] <= bits[63:32];
          blk_r[15] <= bits[31:0];
        end
      end
    end
    if (cmd.pad_final) begin
      for (int j = 0; j < 14; j++) blk_r[j] <= 32'h0;
      blk_r[14] <= bits[63:32];
      blk_r[15] <= bits[31:0];
    end
    if (cmd.load_win) begin
      for (int j = 0; j < 16; j++) win_r[j] <= blk_r[j];
    end else if (cmd.do_round) begin
      for (int j = 0; j < 15; j++) win_r[j] <= win_r[j + 1];
      win_r[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int j = 0; j < 8; j++) h_r[j] <= IV[j];
      fill_r <= 7'd0;
      len_r  <= '0;
    end else begin
      if (cmd.take_byte) begin
        len_r  <= len_r + 61'd1;
        fill_r <= block_full ? 7'd0 : fill_r + 7'd1;
      end
      if (cmd.pad_start) fill_r <= 7'd0;
      if (cmd.fold) begin
        for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_win) begin
      for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
    end else if (cmd.do_round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};

endmodule
`default_nettype wire

/* hdl/sha_ctrl.sv */
// ---------------------------------------------------------------------------
// sha_ctrl: hasher controller
// sequences byte intake, padding, rounds and digest hand-off
// ---------------------------------------------------------------------------
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic       has_byte,
  input  wire logic       end_of_message,
  input  wire logic       out_ready,
  input  wire logic       block_full,
  input  wire logic       need_extra,
  output logic            in_ready,
  output logic            out_valid,
  output cmd_t            cmd,
  output logic [5:0]      round_idx
);

  state_t      state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;   // digest pending after current block
  logic        pad_r, pad_nxt;   // length block still to run
  logic        go_r, go_nxt;     // window load or padding step this cycle
  logic        tail_r, tail_nxt; // padding still to start after this block

  assign round_idx = rnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      fin_r <= 1'b0;
      pad_r <= 1'b0;
      go_r  <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      fin_r <= fin_nxt;
      pad_r <= pad_nxt;
      go_r  <= go_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    fin_nxt = fin_r;
    pad_nxt = pad_r;
    tail_nxt = tail_r;
    go_nxt = 1'b0;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (has_byte && block_full) begin
            cmd.take_byte = 1'b1;
            go_nxt = 1'b1;
            fin_nxt = 1'b0;
            pad_nxt = 1'b0;
            tail_nxt = end_of_message;
            state_nxt = ST_ROUND;
            rnd_nxt = '0;
          end else begin
            cmd.take_byte = has_byte;
            if (end_of_message) begin
              go_nxt = 1'b1;
              fin_nxt = 1'b1;
              pad_nxt = 1'b1;
              state_nxt = ST_ROUND;
              rnd_nxt = '0;
            end
          end
        end
      end
      ST_ROUND: begin
        if (go_r) begin
          if (pad_r && fin_r) begin
            cmd.pad_start = 1'b1;
            go_nxt = 1'b1;
            if (need_extra) begin
              fin_nxt = 1'b0;
              pad_nxt = 1'b1;
            end else begin
              fin_nxt = 1'b1;
              pad_nxt = 1'b0;
            end
          end else begin
            cmd.load_win = 1'b1;
          end
        end else begin
          cmd.do_round = 1'b1;
          rnd_nxt = rnd_r + 6'd1;
          if (rnd_r == LAST_ROUND) state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (go_r) begin
          // length block after the extra pad block
          cmd.pad_final = 1'b1;
          pad_nxt = 1'b0;
          fin_nxt = 1'b1;
          go_nxt = 1'b1;
          state_nxt = ST_ROUND;
        end else begin
          cmd.fold = 1'b1;
          rnd_nxt = '0;
          if (tail_r) begin
            tail_nxt = 1'b0;
            go_nxt = 1'b1;
            pad_nxt = 1'b1;
            fin_nxt = 1'b1;
            state_nxt = ST_ROUND;
          end else if (pad_r) begin
            go_nxt = 1'b1;
            state_nxt = ST_FOLD;
          end else if (fin_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.restart = 1'b1;
          fin_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/sha256_stream_hasher_unit.sv */
// ---------------------------------------------------------------------------
// sha256_stream_hasher_unit: byte-serial SHA-256 hasher
// top level joining controller and datapath
// ---------------------------------------------------------------------------
// One request per cycle while the block buffer fills. The 64th byte of a
// block starts the compression: one round per cycle through a single round
// unit, a window load, 64 rounds and a chaining fold, and the input stalls
// until the fold is done. An end-of-message request adds a padding write
// before the window load, and the digest is offered after the fold, or
// after a second block when the padding needs one (more than 55 bytes
// pending, or the request also closed a full block). The digest is held in
// the chaining registers until taken; the next message starts after that.
`default_nettype none
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sha_in_if.sink      in_ch,
  sha_out_if.source   out_ch
);

  cmd_t         cmd;
  logic         block_full, need_extra;
  logic [5:0]   round_idx;
  logic [255:0] digest;
  logic         in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .has_byte(in_ch.has_byte), .end_of_message(in_ch.end_of_message),
    .out_ready(out_ch.ready), .block_full, .need_extra,
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .cmd, .round_idx
  );

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .byte_in(in_ch.data_byte), .round_idx,
    .block_full, .need_extra, .digest
  );

  assign out_ch.digest_bits_255_192 = digest[255:192];
  assign out_ch.digest_bits_191_128 = digest[191:128];
  assign out_ch.digest_bits_127_64  = digest[127:64];
  assign out_ch.digest_bits_63_0    = digest[63:0];

endmodule
`default_nettype wire

/* tb/sha256_stream_hasher_unit_tb.sv */
// ---------------------------------------------------------------------------
// sha256_stream_hasher_unit_tb: self-checking bench for the byte-serial hasher
// drives message bytes and end-of-message requests, predicts each digest with
// an in-bench sha-256 model and compares every digest word as it is taken
// ---------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_unit_tb
  import sha_pkg::*;
();

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_req_t;

  typedef struct packed {
    logic [63:0] d3;
    logic [63:0] d2;
    logic [63:0] d1;
    logic [63:0] d0;
  } digest_t;

  typedef struct {
    msg_req_t req;
    logic     known;
    digest_t  dig;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [31:0] hash_words [8];
  logic [31:0] msg_block [16];
  int unsigned fill_count;
  logic [60:0] byte_count;
  digest_t     digest_queue [$];
  int          fail_count = 0;
  int          send_idle_pct = 6;
  int          recv_idle_pct = 78;
  int          hold_off = 0;
  int          quiet_cycles = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_words[i] = IV[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    fill_count = 0;
    byte_count = '0;
  endfunction

  function automatic void hash_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    int sh;
    sh = (3 - (fill_count % 4)) * 8;
    msg_block[fill_count / 4] = (msg_block[fill_count / 4] & ~(32'hff << sh)) |
                                (32'(v) << sh);
    fill_count++;
    if (fill_count == 64) begin
      hash_compress();
      fill_count = 0;
    end
  endfunction

  // returns 1 and the digest when the request ends a message
  function automatic logic predict_digest(input msg_req_t r, output digest_t dg);
    logic [63:0] bit_len;
    dg = '0;
    if (r.has_byte) begin
      byte_count = byte_count + 1'b1;
      append_byte(r.data_byte);
    end
    if (!r.end_of_message) return 1'b0;
    bit_len = {byte_count, 3'b000};
    append_byte(PAD_BYTE);
    while (fill_count != PAD_LIMIT) append_byte(8'h00);
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    hash_compress();
    dg = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
          hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
    hash_restart();
    return 1'b1;
  endfunction

  task automatic send_req(input msg_req_t r);
    digest_t dg;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= r.data_byte;
    in_ch.has_byte       <= r.has_byte;
    in_ch.end_of_message <= r.end_of_message;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_digest(r, dg)) digest_queue.push_back(dg);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_queue.size() == 0) begin
          $error("digest with no message pending");
          fail_count++;
        end else begin
          digest_t exp_d;
          exp_d = digest_queue.pop_front();
          if (out_ch.digest_bits_255_192 !== exp_d.d3) begin
            $error("digest_bits_255_192 exp %h got %h", exp_d.d3, out_ch.digest_bits_255_192);
            fail_count++;
          end
          if (out_ch.digest_bits_191_128 !== exp_d.d2) begin
            $error("digest_bits_191_128 exp %h got %h", exp_d.d2, out_ch.digest_bits_191_128);
            fail_count++;
          end
          if (out_ch.digest_bits_127_64 !== exp_d.d1) begin
            $error("digest_bits_127_64 exp %h got %h", exp_d.d1, out_ch.digest_bits_127_64);
            fail_count++;
          end
          if (out_ch.digest_bits_63_0 !== exp_d.d0) begin
            $error("digest_bits_63_0 exp %h got %h", exp_d.d0, out_ch.digest_bits_63_0);
            fail_count++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_message(input int len);
    msg_req_t r;
    for (int i = 0; i < len; i++) begin
      r.data_byte = 8'($urandom);
      r.has_byte = 1'b1;
      r.end_of_message = (i == len - 1) && ($urandom_range(1) == 1);
      if ($urandom_range(19) == 0) send_req('{8'($urandom), 1'b0, 1'b0});
      send_req(r);
      if (r.end_of_message) return;
    end
    send_req('{8'($urandom), 1'b0, 1'b1});
  endtask

  dir_row_t dir_rows [] = '{
    // empty message
    '{'{8'h00, 1'b0, 1'b1}, 1'b1,
      '{64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
        64'h27ae41e4649b934c, 64'ha495991b7852b855}},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    // "abc", last byte with end
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1,
      '{64'hba7816bf8f01cfea, 64'h414140de5dae2223,
        64'hb00361a396177a9c, 64'hb410ff61f20015ad}},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h7f, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0}
  };

  initial begin
    int lens [] = '{55, 56, 63, 64, 65, 119, 120, 128};
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    hash_restart();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req);
      if (dir_rows[i].known) begin
        void'(digest_queue.pop_back());
        digest_queue.push_back(dir_rows[i].dig);
      end
    end
    // padding boundaries
    foreach (lens[i]) begin
      for (int j = 0; j < lens[i]; j++) send_req('{8'($urandom), 1'b1, 1'b0});
      send_req('{8'h00, 1'b0, 1'b1});
    end
    // long receiver hold-off so the held digest stalls the input
    hold_off = 400;
    for (int j = 0; j < 6; j++) send_message($urandom_range(1, 40));
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 6 : 0;
      for (int n = 0; n < 9; n++)
        send_message(($urandom_range(9) == 0) ? $urandom_range(60, 140)
                                               : $urandom_range(0, 40));
    end
    in_ch.valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_stream_hasher_unit.sv
tb/sha256_stream_hasher_unit_tb.sv
